### design/text_console_character_engine_defines.svh
// ----------------------------------------------------------------------------
// Text console character engine assertion macros
// Shared assertion wrappers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_DEFINES_SVH

`ifndef SYNTH
// Checks a property on every rising clock edge outside reset.
`define TCE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("text console engine check failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define TCE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("text console engine sequencing check failed");
`else
`define TCE_ASSERT(lbl, clk, rst, prop)
`define TCE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### design/tce_pkg.sv
// ----------------------------------------------------------------------------
// Text console engine package
// Shared constants, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

   localparam int COLS_DEFAULT     = 80;
   localparam int ROWS_DEFAULT     = 25;
   localparam int TAB_STEP_DEFAULT = 8;

   // Operation codes of the request word.
   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Control characters interpreted by a put.
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LINE_FEED = 8'h0A;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;
   localparam logic [7:0] CHAR_BLANK     = 8'h20;

   localparam logic [7:0]  ATTR_RESET = 8'h0F;
   localparam logic [15:0] CELL_RESET = 16'h0F20;

   typedef enum logic [1:0] {
      SWEEP_HOME       = 2'd0,
      SWEEP_SECOND_ROW = 2'd1,
      SWEEP_LAST_ROW   = 2'd2
   } sweep_start_type;

   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_EXEC  = 7'b0000100,
      ST_COPY  = 7'b0001000,
      ST_DRAIN = 7'b0010000,
      ST_FILL  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic            capture;
      logic            execute;
      logic            sweep_load;
      sweep_start_type sweep_start;
      logic            copy_step;
      logic            fill_step;
      logic            fill_init;
      logic            result_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       scroll;
      logic       sweep_end;
   } status_type;

endpackage

`default_nettype wire

### design/tce_datapath.sv
// ----------------------------------------------------------------------------
// Text console engine datapath
// Screen memory, cursor registers, sweep counter and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_datapath #(
   parameter int COLS     = tce_pkg::COLS_DEFAULT,
   parameter int ROWS     = tce_pkg::ROWS_DEFAULT,
   parameter int TAB_STEP = tce_pkg::TAB_STEP_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [7:0]           csr_data,
   input  wire logic [1:0]           op,
   input  wire logic [7:0]           char_code,
   input  wire logic [10:0]          cell_index,
   input  wire tce_pkg::cmd_type     cmd,
   output tce_pkg::status_type       status,
   output logic [10:0]               cursor_index,
   output logic [15:0]               read_cell,
   output logic                      scrolled
);

   localparam int CELLS = COLS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLS);
   localparam int CXW   = CW + 2;
   localparam int RW    = $clog2(ROWS);
   localparam int PW    = $clog2(TAB_STEP);
   localparam int IXW   = (AW > 11) ? AW : 11;

   logic [15:0]    mem [CELLS];

   logic [1:0]     op_ff;
   logic [7:0]     char_ff;
   logic [10:0]    cidx_ff;
   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [PW-1:0]  phase_ff, phase_in;
   logic [7:0]     attr_ff;
   logic [AW-1:0]  sweep_ff, sweep_in;
   logic           scrolled_ff;
   logic           wr_pend_ff;
   logic [AW-1:0]  wr_addr_ff;
   logic [15:0]    rd_data_ff;
   logic [10:0]    rsp_cursor_ff;
   logic [15:0]    rsp_cell_ff;
   logic           rsp_scrolled_ff;

   logic [CXW-1:0] col_x;
   logic [RW:0]    row_x;
   logic [PW-1:0]  phase_x;
   logic           scroll_x;
   logic           printable;
   logic [AW-1:0]  cur_idx;
   logic [IXW-1:0] cur_idx_wide;
   logic [IXW-1:0] cidx_wide;
   logic           cidx_in_range;
   logic           we;
   logic [AW-1:0]  waddr;
   logic [15:0]    wdata;
   logic [AW-1:0]  raddr;

   assign printable     = (char_ff >= tce_pkg::CHAR_BLANK);
   assign cur_idx       = AW'(row_ff) * AW'(COLS) + AW'(col_ff);
   assign cur_idx_wide  = IXW'(cur_idx);
   assign cidx_wide     = IXW'(cidx_ff);
   assign cidx_in_range = ({1'b0, cidx_wide} < (IXW + 1)'(CELLS));

   // Cursor movement of a put. The tab phase tracks the column modulo the tab width.
   always_comb begin
      col_x   = CXW'(col_ff);
      row_x   = (RW + 1)'(row_ff);
      phase_x = phase_ff;
      case (char_ff)
         tce_pkg::CHAR_BACKSPACE: begin
            if (col_ff != '0) begin
               col_x   = CXW'(col_ff) - CXW'(1);
               phase_x = (phase_ff == '0) ? PW'(TAB_STEP - 1) : phase_ff - PW'(1);
            end
         end
         tce_pkg::CHAR_TAB: begin
            col_x   = CXW'(col_ff) + CXW'(TAB_STEP) - CXW'(phase_ff);
            phase_x = '0;
         end
         tce_pkg::CHAR_RETURN: begin
            col_x   = '0;
            phase_x = '0;
         end
         tce_pkg::CHAR_LINE_FEED: begin
            col_x   = '0;
            phase_x = '0;
            row_x   = (RW + 1)'(row_ff) + (RW + 1)'(1);
         end
         default: begin
            if (printable) begin
               col_x   = CXW'(col_ff) + CXW'(1);
               phase_x = (phase_ff == PW'(TAB_STEP - 1)) ? '0 : phase_ff + PW'(1);
            end
         end
      endcase
      if (col_x >= CXW'(COLS)) begin
         col_x   = '0;
         phase_x = '0;
         row_x   = row_x + (RW + 1)'(1);
      end
      scroll_x = (row_x >= (RW + 1)'(ROWS));
      if (scroll_x) begin
         row_x = (RW + 1)'(ROWS - 1);
      end
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      phase_in = phase_ff;
      if (cmd.execute && (op_ff == tce_pkg::OP_PUT)) begin
         col_in   = col_x[CW-1:0];
         row_in   = row_x[RW-1:0];
         phase_in = phase_x;
      end else if (cmd.execute && (op_ff == tce_pkg::OP_CLEAR)) begin
         col_in   = '0;
         row_in   = '0;
         phase_in = '0;
      end
   end

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_load) begin
         case (cmd.sweep_start)
            tce_pkg::SWEEP_HOME:       sweep_in = '0;
            tce_pkg::SWEEP_SECOND_ROW: sweep_in = AW'(COLS);
            tce_pkg::SWEEP_LAST_ROW:   sweep_in = AW'(CELLS - COLS);
            default:                   sweep_in = '0;
         endcase
      end else if (cmd.copy_step || cmd.fill_step) begin
         sweep_in = sweep_ff + AW'(1);
      end
   end

   // One write port: the delayed copy write, then blanking, then a character.
   always_comb begin
      we    = 1'b0;
      waddr = sweep_ff;
      wdata = {attr_ff, tce_pkg::CHAR_BLANK};
      if (wr_pend_ff) begin
         we    = 1'b1;
         waddr = wr_addr_ff;
         wdata = rd_data_ff;
      end else if (cmd.fill_step) begin
         we    = 1'b1;
         wdata = cmd.fill_init ? tce_pkg::CELL_RESET : {attr_ff, tce_pkg::CHAR_BLANK};
      end else if (cmd.execute && (op_ff == tce_pkg::OP_PUT) && printable) begin
         we    = 1'b1;
         waddr = cur_idx;
         wdata = {attr_ff, char_ff};
      end
   end

   assign raddr = cmd.copy_step ? sweep_ff : cidx_wide[AW-1:0];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         phase_ff    <= '0;
         attr_ff     <= tce_pkg::ATTR_RESET;
         sweep_ff    <= '0;
         wr_pend_ff  <= 1'b0;
         scrolled_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         phase_ff   <= phase_in;
         sweep_ff   <= sweep_in;
         wr_pend_ff <= cmd.copy_step;
         if (csr_write) begin
            attr_ff <= csr_data;
         end
         if (cmd.execute) begin
            scrolled_ff <= (op_ff == tce_pkg::OP_PUT) && scroll_x;
         end
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= sweep_ff - AW'(COLS);
      if (cmd.capture) begin
         op_ff   <= op;
         char_ff <= char_code;
         cidx_ff <= cell_index;
      end
      if (cmd.result_load) begin
         rsp_cursor_ff   <= cur_idx_wide[10:0];
         rsp_cell_ff     <= ((op_ff == tce_pkg::OP_READ) && cidx_in_range) ? rd_data_ff : '0;
         rsp_scrolled_ff <= scrolled_ff;
      end
   end

   assign status.op        = op_ff;
   assign status.scroll    = scroll_x;
   assign status.sweep_end = (sweep_ff == AW'(CELLS - 1));

   assign cursor_index = rsp_cursor_ff;
   assign read_cell    = rsp_cell_ff;
   assign scrolled     = rsp_scrolled_ff;

endmodule

`default_nettype wire

### design/tce_controller.sv
// ----------------------------------------------------------------------------
// Text console engine controller
// Sequences item execution, scroll copy, screen blanking and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_character_engine_defines.svh"

module tce_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire tce_pkg::status_type status,
   output tce_pkg::cmd_type         cmd
);

   tce_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == tce_pkg::ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.sweep_start = tce_pkg::SWEEP_HOME;
      case (state_ff)
         tce_pkg::ST_INIT: begin
            cmd.fill_step = 1'b1;
            cmd.fill_init = 1'b1;
            if (status.sweep_end) begin
               state_in = tce_pkg::ST_IDLE;
            end
         end
         tce_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = tce_pkg::ST_EXEC;
            end
         end
         tce_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
            if ((status.op == tce_pkg::OP_PUT) && status.scroll) begin
               cmd.sweep_load  = 1'b1;
               cmd.sweep_start = tce_pkg::SWEEP_SECOND_ROW;
               state_in        = tce_pkg::ST_COPY;
            end else if (status.op == tce_pkg::OP_CLEAR) begin
               cmd.sweep_load  = 1'b1;
               cmd.sweep_start = tce_pkg::SWEEP_HOME;
               state_in        = tce_pkg::ST_FILL;
            end else begin
               state_in = tce_pkg::ST_DONE;
            end
         end
         tce_pkg::ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.sweep_end) begin
               state_in = tce_pkg::ST_DRAIN;
            end
         end
         tce_pkg::ST_DRAIN: begin
            cmd.sweep_load  = 1'b1;
            cmd.sweep_start = tce_pkg::SWEEP_LAST_ROW;
            state_in        = tce_pkg::ST_FILL;
         end
         tce_pkg::ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.sweep_end) begin
               state_in = tce_pkg::ST_DONE;
            end
         end
         tce_pkg::ST_DONE: begin
            if (slot_free) begin
               cmd.result_load = 1'b1;
               state_in        = tce_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tce_pkg::ST_INIT;
         end
      endcase
   end

   assign rsp_valid_in = cmd.result_load || (rsp_valid_ff && !rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tce_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TCE_ASSERT_NEXT(a_accept_executes, clock, reset, req_tvalid && req_tready, state_ff == tce_pkg::ST_EXEC)
   `TCE_ASSERT_NEXT(a_scroll_copies, clock, reset, (state_ff == tce_pkg::ST_EXEC) && (status.op == tce_pkg::OP_PUT) && status.scroll, state_ff == tce_pkg::ST_COPY)
   `TCE_ASSERT_NEXT(a_drain_fills, clock, reset, state_ff == tce_pkg::ST_DRAIN, state_ff == tce_pkg::ST_FILL)
   `TCE_ASSERT(a_step_exclusive, clock, reset, !(cmd.copy_step && cmd.fill_step))

endmodule

`default_nettype wire

### design/text_console_character_engine.sv
// ----------------------------------------------------------------------------
// Text console character engine
// Character-cell console with a screen memory, cursor, scrolling and clear.
// ----------------------------------------------------------------------------
// Usage: a request word carries an operation (put character, clear screen or
// read one cell). Every accepted request returns exactly one response word
// with the cursor index after the request, the cell read (zero for other
// operations or an index past the screen) and a flag that marks a scroll.
// A put or read passes from acceptance through the accept, execute and
// hand-off steps to a response in the output register. A put that scrolls
// adds a copy of rows 1 to ROWS-1 one row up, a drain step and blanking of
// the last row; a clear adds blanking of the whole screen. The screen memory
// has one write port and one read port; it moves one cell per cycle.
// After reset the engine writes the blank cell 0x0F20 over the whole
// screen; req_tready stays low during this pass, while attribute writes on
// the csr channel are taken at any time.
// A finished response waits in the output register while the next request is
// accepted and executed; if the receiver still stalls when that next response
// is ready, the engine holds it and does not accept further requests.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_character_engine #(
   parameter int COLS     = tce_pkg::COLS_DEFAULT,
   parameter int ROWS     = tce_pkg::ROWS_DEFAULT,
   parameter int TAB_STEP = tce_pkg::TAB_STEP_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request word: op [1:0], char_code [9:2], cell_index [20:10], zero [23:21].
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,
   // Response word: cursor_index [10:0], read_cell [26:11], scrolled [27],
   // zero [31:28].
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,
   // Attribute register write: text_attribute [7:0].
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data
);

   tce_pkg::cmd_type    cmd;
   tce_pkg::status_type status;
   logic [10:0]         cursor_index;
   logic [15:0]         read_cell;
   logic                scrolled;

   // The attribute register is always ready to take a write.
   assign csr_ready = 1'b1;

   tce_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tce_datapath #(
      .COLS     (COLS),
      .ROWS     (ROWS),
      .TAB_STEP (TAB_STEP)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_valid && csr_ready),
      .csr_data     (csr_data),
      .op           (req_tdata[1:0]),
      .char_code    (req_tdata[9:2]),
      .cell_index   (req_tdata[20:10]),
      .cmd          (cmd),
      .status       (status),
      .cursor_index (cursor_index),
      .read_cell    (read_cell),
      .scrolled     (scrolled)
   );

   // Response fields packed from the lowest bit up.
   assign rsp_tdata = {4'b0000, scrolled, read_cell, cursor_index};

endmodule

`default_nettype wire

### dv/text_console_character_engine_test.sv
// ----------------------------------------------------------------------------
// Text console character engine testbench
// Drives request words (put, clear, read and the unused operation) through
// the streaming input, predicts every response with a shadow screen and
// cursor, and checks each response word field by field. Attribute settings
// change between phases while the engine is idle, and both stream sides
// idle in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_character_engine_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS       = tce_pkg::COLS_DEFAULT;
   localparam int ROWS       = tce_pkg::ROWS_DEFAULT;
   localparam int TAB_STEP   = tce_pkg::TAB_STEP_DEFAULT;
   localparam int CELLS      = COLS * ROWS;
   localparam int PHASE_LEN  = 135;
   localparam int HOLD_LEN   = 400;
   localparam int DIRECTED_N = 27;

   // The fourth operation code has no meaning; the engine only reports the cursor.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // One response word, unpacked.
   typedef struct packed {
      logic [10:0] cursor_index;
      logic [15:0] read_cell;
      logic        scrolled;
   } console_rsp_type;

   // One directed stimulus line. When known is set, the response is typed
   // in here instead of taken from the shadow model.
   typedef struct packed {
      logic [1:0]      op;
      logic [7:0]      char_code;
      logic [10:0]     cell_index;
      int              repeats;
      bit              known;
      console_rsp_type want;
   } stim_line_type;

   // What the sender promised for a word that the engine has not taken yet.
   typedef struct packed {
      bit              known;
      console_rsp_type want;
   } offer_note_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;

   // Shadow copy of the engine state.
   logic [15:0] shadow_screen [CELLS];
   int          shadow_col;
   int          shadow_row;
   logic [7:0]  shadow_attr;

   console_rsp_type awaited_responses [$];
   offer_note_type  offered_words [$];
   int              error_count;
   bit              calm;
   bit              hold_off;
   bit              hold_done;

   text_console_character_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Applies one request word to the shadow state and returns the response
   // the engine has to give for it.
   function automatic console_rsp_type console_after_word(input logic [1:0]  op,
                                                          input logic [7:0]  code,
                                                          input logic [10:0] idx);
      console_rsp_type rsp;
      int              linear;
      rsp = '0;
      case (op)
         tce_pkg::OP_PUT: begin
            if (code == tce_pkg::CHAR_BACKSPACE) begin
               // Backspace never leaves the current line.
               if (shadow_col != 0) shadow_col--;
            end else if (code == tce_pkg::CHAR_TAB) begin
               shadow_col = shadow_col + TAB_STEP - (shadow_col % TAB_STEP);
            end else if (code == tce_pkg::CHAR_RETURN) begin
               shadow_col = 0;
            end else if (code == tce_pkg::CHAR_LINE_FEED) begin
               shadow_col = 0;
               shadow_row++;
            end else if (code >= tce_pkg::CHAR_BLANK) begin
               // Every code from the blank upward, the high half included, is printed.
               linear = shadow_row * COLS + shadow_col;
               if (linear < CELLS) shadow_screen[linear] = {shadow_attr, code};
               shadow_col++;
            end
            if (shadow_col >= COLS) begin
               shadow_col = 0;
               shadow_row++;
            end
            if (shadow_row >= ROWS) begin
               // Scroll up by one line and blank the bottom line.
               for (int i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
               for (int i = CELLS - COLS; i < CELLS; i++) begin
                  shadow_screen[i] = {shadow_attr, tce_pkg::CHAR_BLANK};
               end
               shadow_row   = ROWS - 1;
               rsp.scrolled = 1'b1;
            end
         end
         tce_pkg::OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++) shadow_screen[i] = {shadow_attr, tce_pkg::CHAR_BLANK};
            shadow_col = 0;
            shadow_row = 0;
         end
         tce_pkg::OP_READ: begin
            if (idx < CELLS) rsp.read_cell = shadow_screen[idx];
         end
         default: begin
         end
      endcase
      rsp.cursor_index = 11'(shadow_row * COLS + shadow_col);
      return rsp;
   endfunction

   // Scoreboard: the engine takes a word, the shadow model predicts its
   // response; the engine hands back a response, it is checked against the
   // oldest prediction.
   always @(posedge clock) begin
      console_rsp_type want;
      console_rsp_type got;
      console_rsp_type predicted;
      offer_note_type  note;
      if (reset) begin
         shadow_attr = tce_pkg::ATTR_RESET;
         shadow_col  = 0;
         shadow_row  = 0;
         for (int i = 0; i < CELLS; i++) shadow_screen[i] = tce_pkg::CELL_RESET;
      end else begin
         if (csr_valid && csr_ready) shadow_attr = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            // The response word carries the cursor in its lowest bits.
            got.cursor_index = rsp_tdata[10:0];
            got.read_cell    = rsp_tdata[26:11];
            got.scrolled     = rsp_tdata[27];
            if (awaited_responses.size() == 0) begin
               error_count++;
               $display("%0t: response with nothing awaited, expected none actual %0h",
                        $time, rsp_tdata);
            end else begin
               want = awaited_responses.pop_front();
               if (got.cursor_index !== want.cursor_index) begin
                  error_count++;
                  $display("%0t: cursor_index mismatch, expected %0d actual %0d",
                           $time, want.cursor_index, got.cursor_index);
               end
               if (got.read_cell !== want.read_cell) begin
                  error_count++;
                  $display("%0t: read_cell mismatch, expected %h actual %h",
                           $time, want.read_cell, got.read_cell);
               end
               if (got.scrolled !== want.scrolled) begin
                  error_count++;
                  $display("%0t: scrolled mismatch, expected %0b actual %0b",
                           $time, want.scrolled, got.scrolled);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            note      = offered_words.pop_front();
            predicted = console_after_word(req_tdata[1:0], req_tdata[9:2], req_tdata[20:10]);
            awaited_responses.push_back(note.known ? note.want : predicted);
         end
      end
   end

   // Offers one request word and returns once the engine has taken it. A
   // random idle burst may come first unless the run is in its calm part.
   task automatic offer_word(input logic [1:0]      op,
                             input logic [7:0]      code,
                             input logic [10:0]     idx,
                             input bit              known,
                             input console_rsp_type want);
      int             gap;
      offer_note_type note;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      note.known = known;
      note.want  = want;
      offered_words.push_back(note);
      req_tvalid = 1'b1;
      req_tdata  = {3'b000, idx, code, op};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drops valid and waits until every response has come back, so that the
   // engine is idle afterwards.
   task automatic drain_engine();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (awaited_responses.size() != 0 || offered_words.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_attribute(input logic [7:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Draws one random request word. Most words are puts of printable text,
   // with control codes, reads near the cursor and now and then a clear.
   task automatic random_word(output logic [1:0]  op,
                              output logic [7:0]  code,
                              output logic [10:0] idx);
      int pick;
      int near;
      pick = $urandom_range(0, 99);
      code = 8'($urandom_range(0, 255));
      idx  = 11'($urandom_range(0, 2047));
      if (pick < 1) begin
         op = tce_pkg::OP_CLEAR;
      end else if (pick < 4) begin
         op = OP_UNUSED;
      end else if (pick < 19) begin
         op   = tce_pkg::OP_READ;
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            idx = 11'($urandom_range(CELLS, 2047));
         end else if (pick < 55) begin
            // Reads just behind the cursor find freshly printed cells.
            near = shadow_row * COLS + shadow_col - $urandom_range(0, 100);
            idx  = 11'((near < 0) ? 0 : near);
         end else begin
            idx = 11'($urandom_range(0, CELLS - 1));
         end
      end else begin
         op   = tce_pkg::OP_PUT;
         pick = $urandom_range(0, 99);
         if (pick < 6) code = tce_pkg::CHAR_LINE_FEED;
         else if (pick < 9) code = tce_pkg::CHAR_RETURN;
         else if (pick < 13) code = tce_pkg::CHAR_BACKSPACE;
         else if (pick < 17) code = tce_pkg::CHAR_TAB;
         else if (pick < 20) code = 8'($urandom_range(0, 31));
         else code = 8'($urandom_range(32, 255));
      end
   endtask

   // Response side: ready comes and goes in random bursts, apart from one
   // long hold-off that lets the engine back up into its input, and none at
   // all in the calm part.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off && !hold_done) begin
            rsp_tready = 1'b0;
            repeat (HOLD_LEN - 1) @(negedge clock);
            hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
            repeat ($urandom_range(1, 16) - 1) @(negedge clock);
         end
      end
   end

   // Main stimulus sequence.
   initial begin
      stim_line_type directed [DIRECTED_N];
      logic [7:0]    phase_attr [5];
      logic [1:0]    op;
      logic [7:0]    code;
      logic [10:0]   idx;

      // The directed lines start from the reset screen and cursor, with the
      // reset attribute. Typed responses are the ones plain from the rules.
      directed = '{
         // Reads of the first, last and two missing cells of the reset screen.
         '{tce_pkg::OP_READ,  8'h00, 11'd0,    1, 1'b1, '{11'd0,    16'h0F20, 1'b0}},
         '{tce_pkg::OP_READ,  8'h00, 11'd1999, 1, 1'b1, '{11'd0,    16'h0F20, 1'b0}},
         '{tce_pkg::OP_READ,  8'h00, 11'd2000, 1, 1'b1, '{11'd0,    16'h0000, 1'b0}},
         '{tce_pkg::OP_READ,  8'hFF, 11'd2047, 1, 1'b1, '{11'd0,    16'h0000, 1'b0}},
         // The unused operation only reports the cursor.
         '{OP_UNUSED,         8'hFF, 11'd2047, 1, 1'b1, '{11'd0,    16'h0000, 1'b0}},
         // Backspace at the left edge stays put.
         '{tce_pkg::OP_PUT,   tce_pkg::CHAR_BACKSPACE, 11'd0, 1, 1'b1,
           '{11'd0, 16'h0000, 1'b0}},
         '{tce_pkg::OP_PUT,   8'h41, 11'd0,    1, 1'b1, '{11'd1,    16'h0000, 1'b0}},
         '{tce_pkg::OP_READ,  8'h00, 11'd0,    1, 1'b1, '{11'd1,    16'h0F41, 1'b0}},
         // High codes are printed like any other.
         '{tce_pkg::OP_PUT,   8'hFF, 11'd0,    1, 1'b0, '0},
         '{tce_pkg::OP_PUT,   8'h7F, 11'd0,    1, 1'b0, '0},
         '{tce_pkg::OP_PUT,   tce_pkg::CHAR_BLANK, 11'd0, 1, 1'b0, '0},
         // Other control codes neither print nor move; the interpreted ones follow.
         '{tce_pkg::OP_PUT,   8'h00, 11'd0,    1, 1'b1, '{11'd4,    16'h0000, 1'b0}},
         '{tce_pkg::OP_PUT,   8'h1F, 11'd0,    1, 1'b0, '0},
         '{tce_pkg::OP_PUT,   tce_pkg::CHAR_BACKSPACE, 11'd0, 1, 1'b0, '0},
         '{tce_pkg::OP_PUT,   tce_pkg::CHAR_TAB,       11'd0, 1, 1'b0, '0},
         '{tce_pkg::OP_PUT,   tce_pkg::CHAR_RETURN,    11'd0, 1, 1'b0, '0},
         '{tce_pkg::OP_PUT,   tce_pkg::CHAR_LINE_FEED, 11'd0, 1, 1'b0, '0},
         '{tce_pkg::OP_READ,  8'h00, 11'd1,    1, 1'b0, '0},
         '{tce_pkg::OP_CLEAR, 8'h00, 11'd0,    1, 1'b1, '{11'd0,    16'h0000, 1'b0}},
         '{tce_pkg::OP_READ,  8'h00, 11'd1,    1, 1'b1, '{11'd0,    16'h0F20, 1'b0}},
         // Tabs up to the last stop, then one more wraps to the next line.
         '{tce_pkg::OP_PUT,   tce_pkg::CHAR_TAB, 11'd0, 9, 1'b0, '0},
         '{tce_pkg::OP_PUT,   tce_pkg::CHAR_TAB, 11'd0, 1, 1'b1, '{11'd80, 16'h0000, 1'b0}},
         '{tce_pkg::OP_PUT,   8'h0B, 11'd0,    1, 1'b0, '0},
         // Line feeds down to the bottom line, then one that scrolls.
         '{tce_pkg::OP_PUT,   tce_pkg::CHAR_LINE_FEED, 11'd0, 23, 1'b0, '0},
         '{tce_pkg::OP_PUT,   tce_pkg::CHAR_LINE_FEED, 11'd0, 1, 1'b1,
           '{11'd1920, 16'h0000, 1'b1}},
         '{tce_pkg::OP_READ,  8'h00, 11'd1920, 1, 1'b1, '{11'd1920, 16'h0F20, 1'b0}},
         '{tce_pkg::OP_READ,  8'h00, 11'd1999, 1, 1'b0, '0}
      };
      phase_attr = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255))};

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      error_count = 0;
      calm        = 1'b0;
      hold_off    = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The engine blanks the screen after reset with req_tready low; the
      // first offer simply waits that pass out.
      foreach (directed[n]) begin
         repeat (directed[n].repeats) begin
            offer_word(directed[n].op, directed[n].char_code, directed[n].cell_index,
                       directed[n].known, directed[n].want);
         end
      end
      drain_engine();

      // Random phases, each under its own attribute. The second phase opens
      // with a long response hold-off so the engine fills and stalls its
      // input; the last phase runs without idle bursts.
      for (int phase = 0; phase < 5; phase++) begin
         write_attribute(phase_attr[phase]);
         if (phase == 1) hold_off = 1'b1;
         if (phase == 4) calm = 1'b1;
         for (int n = 0; n < PHASE_LEN; n++) begin
            random_word(op, code, idx);
            offer_word(op, code, idx, 1'b0, '0);
         end
         drain_engine();
      end

      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("text_console_character_engine test passed");
      end else begin
         $display("text_console_character_engine test failed");
      end
      $finish;
   end

   // Watchdog, far beyond a run in which every word clears or scrolls.
   initial begin
      #40_000_000;
      $display("text_console_character_engine test failed");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
+incdir+design
design/tce_pkg.sv
design/tce_datapath.sv
design/tce_controller.sv
design/text_console_character_engine.sv
dv/text_console_character_engine_test.sv
